### sv/deque_with_search_macros.svh
// ----------------------------------------------------------------------------
// deque_with_search assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_SEARCH_MACROS_SVH
`define DEQUE_WITH_SEARCH_MACROS_SVH

`ifndef ASSERT_OFF
`define DWS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DWS_ASSERT(label, clk, rst_n, prop, msg)
`define DWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### sv/dws_pkg.sv
// ----------------------------------------------------------------------------
// dws_pkg
// shared types, action codes and default sizes for the searchable deque
// ----------------------------------------------------------------------------
package dws_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int ACTION_W        = 3;
    localparam int IN_VALUE_W      = 32;
    localparam int COUNT_OUT_W     = 5;

    typedef logic [ACTION_W-1:0] t_action;

    localparam t_action ACT_PUSH_FRONT = 3'd0;
    localparam t_action ACT_POP_FRONT  = 3'd1;
    localparam t_action ACT_PUSH_BACK  = 3'd2;
    localparam t_action ACT_POP_BACK   = 3'd3;
    localparam t_action ACT_SEARCH     = 3'd4;

    typedef struct packed {
        logic found;
        logic empty_error;
        logic full_error;
    } t_result;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

### sv/deque_with_search.sv
// ----------------------------------------------------------------------------
// deque_with_search
// bounded double-ended queue of signed values with linear search.
// entries live in a circular single-port-read store addressed from a head
// slot and a count. push front, pop front, push back, pop back and unused
// actions commit in the cycle the word is accepted, as does a search of an
// empty deque; the result goes to a staging register, then to the output
// register. other searches walk the stored entries through the store's one
// read port, one entry per cycle, before the result is staged. one result
// can wait at the output while the next word is accepted and finished.
// ----------------------------------------------------------------------------
`include "deque_with_search_macros.svh"

module deque_with_search
    import dws_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ACTION_W-1:0]          i_action,
    input  logic signed [IN_VALUE_W-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_found,
    output logic                         o_empty_error,
    output logic                         o_full_error,
    output logic [COUNT_OUT_W-1:0]       o_entry_count
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                   w_res_valid;
    logic                   w_res_take;
    t_result                w_res;
    logic [CW-1:0]          w_count;
    t_mem_ctl               w_mem_ctl;
    logic [IW-1:0]          w_waddr;
    logic [VALUE_WIDTH-1:0] w_wdata;
    logic [IW-1:0]          w_raddr;
    logic [VALUE_WIDTH-1:0] w_rdata;
    logic                   w_full_push;
    logic                   w_flag_clash;

    logic                   r_o_valid;
    t_result                r_o_res;
    logic [COUNT_OUT_W-1:0] r_o_count;

    dws_seq #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_value     (i_value),
        .o_res_valid (w_res_valid),
        .i_res_take  (w_res_take),
        .o_res       (w_res),
        .o_count     (w_count),
        .o_mem_ctl   (w_mem_ctl),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    dws_store #(
        .DEPTH (DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // output register, refilled from the staged result as it drains
    assign w_res_take = w_res_valid && (!r_o_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_res_take) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_o_res   <= w_res;
            r_o_count <= COUNT_OUT_W'(w_count);
        end
    end

    assign o_valid       = r_o_valid;
    assign o_found       = r_o_res.found;
    assign o_empty_error = r_o_res.empty_error;
    assign o_full_error  = r_o_res.full_error;
    assign o_entry_count = r_o_count;

    assign w_full_push  = i_valid && o_ready && (w_count == CW'(DEPTH)) &&
                          ((i_action == ACT_PUSH_FRONT) || (i_action == ACT_PUSH_BACK));
    assign w_flag_clash = (o_found && o_empty_error) || (o_found && o_full_error) ||
                          (o_empty_error && o_full_error);

    `DWS_ASSERT(a_count_bound, i_clk, i_rst_n, w_count <= CW'(DEPTH), "count above depth")
    `DWS_ASSERT_NEXT(a_full_push, i_clk, i_rst_n, w_full_push, $stable(w_count), "count changed")
    `DWS_ASSERT(a_flags_exclusive, i_clk, i_rst_n, !(o_valid && w_flag_clash), "flags overlap")

endmodule

### sv/dws_store.sv
// ----------------------------------------------------------------------------
// dws_store
// entry memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module dws_store
    import dws_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  t_mem_ctl                 i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/dws_seq.sv
// ----------------------------------------------------------------------------
// dws_seq
// head and count bookkeeping, store addressing and the search walk
// ----------------------------------------------------------------------------
module dws_seq
    import dws_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  t_action                    i_action,
    input  logic signed [IN_VALUE_W-1:0] i_value,
    output logic                       o_res_valid,
    input  logic                       i_res_take,
    output t_result                    o_res,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output t_mem_ctl                   o_mem_ctl,
    output logic [$clog2(DEPTH)-1:0]   o_waddr,
    output logic [VALUE_WIDTH-1:0]     o_wdata,
    output logic [$clog2(DEPTH)-1:0]   o_raddr,
    input  logic [VALUE_WIDTH-1:0]     i_rdata
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_SEARCH = 1'b1;

    logic                   r_state, n_state;
    logic [IW-1:0]          r_head, n_head;
    logic [CW-1:0]          r_count, n_count;
    logic [IW-1:0]          r_ptr, n_ptr;
    logic [CW-1:0]          r_left, n_left;
    logic                   r_rd_pend, n_rd_pend;
    logic [VALUE_WIDTH-1:0] r_key, n_key;
    logic                   r_found, n_found;
    logic                   r_res_valid, n_res_valid;
    t_result                r_res, n_res;

    logic                   accept;
    logic                   is_full;
    logic                   is_empty;
    logic [IW-1:0]          head_dec;
    logic [IW-1:0]          head_inc;
    logic [IW-1:0]          ptr_inc;
    logic [CW:0]            back_sum;
    logic [IW-1:0]          back_slot;
    logic [VALUE_WIDTH-1:0] key_in;

    assign o_ready  = (r_state == ST_IDLE) && !r_res_valid;
    assign accept   = i_valid && o_ready;
    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);
    assign key_in   = VALUE_WIDTH'(i_value);

    assign head_dec  = (r_head == '0) ? IW'(DEPTH - 1) : r_head - 1'b1;
    assign head_inc  = (r_head == IW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign ptr_inc   = (r_ptr == IW'(DEPTH - 1)) ? '0 : r_ptr + 1'b1;
    assign back_sum  = (CW+1)'(r_head) + (CW+1)'(r_count);
    assign back_slot = (back_sum >= (CW+1)'(DEPTH)) ? IW'(back_sum - (CW+1)'(DEPTH))
                                                    : IW'(back_sum);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_left      = r_left;
        n_rd_pend   = 1'b0;
        n_key       = r_key;
        n_found     = r_found;
        n_res_valid = r_res_valid && !i_res_take;
        n_res       = r_res;
        o_mem_ctl   = '0;
        o_waddr     = head_dec;
        o_wdata     = key_in;
        o_raddr     = r_ptr;

        if (accept) begin
            n_res_valid = 1'b1;
            n_res       = '0;
            case (i_action)
                ACT_PUSH_FRONT: begin
                    if (is_full) begin
                        n_res.full_error = 1'b1;
                    end else begin
                        o_mem_ctl.wr_en = 1'b1;
                        o_waddr         = head_dec;
                        n_head          = head_dec;
                        n_count         = r_count + 1'b1;
                    end
                end
                ACT_POP_FRONT: begin
                    if (is_empty) begin
                        n_res.empty_error = 1'b1;
                    end else begin
                        n_head  = head_inc;
                        n_count = r_count - 1'b1;
                    end
                end
                ACT_PUSH_BACK: begin
                    if (is_full) begin
                        n_res.full_error = 1'b1;
                    end else begin
                        o_mem_ctl.wr_en = 1'b1;
                        o_waddr         = back_slot;
                        n_count         = r_count + 1'b1;
                    end
                end
                ACT_POP_BACK: begin
                    if (is_empty) begin
                        n_res.empty_error = 1'b1;
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                end
                ACT_SEARCH: begin
                    if (!is_empty) begin
                        n_res_valid = 1'b0;
                        n_state     = ST_SEARCH;
                        n_left      = r_count;
                        n_ptr       = r_head;
                        n_key       = key_in;
                        n_found     = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end else if (r_state == ST_SEARCH) begin
            if (r_left != '0) begin
                o_mem_ctl.rd_en = 1'b1;
                n_ptr           = ptr_inc;
                n_left          = r_left - 1'b1;
                n_rd_pend       = 1'b1;
            end
            if (r_rd_pend && (i_rdata == r_key)) begin
                n_found = 1'b1;
            end
            if ((r_left == '0) && !r_rd_pend) begin
                n_state     = ST_IDLE;
                n_res_valid = 1'b1;
                n_res       = '0;
                n_res.found = r_found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_rd_pend   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_rd_pend   <= n_rd_pend;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_left  <= n_left;
        r_key   <= n_key;
        r_found <= n_found;
        r_res   <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_count     = r_count;

endmodule
